@@ design/d2q9_bgk_cell_collision_macros.svh @@
// Assertion helpers shared by the collision block.
`ifndef D2Q9_BGK_CELL_COLLISION_MACROS_SVH
`define D2Q9_BGK_CELL_COLLISION_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define D2Q9_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define D2Q9_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/d2q9_pkg.sv @@
package d2q9_pkg;

    localparam int VW    = 32;          // value width
    localparam int FB    = 28;          // fraction bits
    localparam int NDIR  = 9;
    localparam int RW    = 30;          // relaxation rate width
    localparam int SUMW  = 36;          // sum of nine values
    localparam int MOMW  = 35;          // first moment
    localparam int QW    = 32;          // quotient bits, one per divider stage
    localparam int DW    = 31;          // divisor / remainder bits
    localparam int PW    = 2 * VW - FB; // product after the fraction shift
    localparam int PSTG  = 11;          // stages after the divider

    localparam logic [RW-1:0] RELAX_RESET = 30'd268435456;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] ONE_Q   = VW'(64'd1 << FB);

    // Divide by nine: reciprocal estimate over a biased 35-bit operand.
    localparam logic [31:0]     RECIP9     = 32'd3817748707;
    localparam logic [MOMW-1:0] FEQ_OFFSET = 35'd9663676416;  // 9 * 2^30
    localparam logic [QW:0]     FEQ_BIAS   = 33'd1073741824;  // 2^30

    localparam int DIR_X [NDIR]    = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [NDIR]    = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int WEIGHT36 [NDIR] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};

    typedef logic signed [VW-1:0] val_t;
    typedef logic [NDIR-1:0][VW-1:0] pops_t;

    typedef struct packed {
        val_t pop_rest;
        val_t pop_east;
        val_t pop_north;
        val_t pop_west;
        val_t pop_south;
        val_t pop_northeast;
        val_t pop_northwest;
        val_t pop_southwest;
        val_t pop_southeast;
    } cell_t;

    typedef struct packed {
        val_t post_rest;
        val_t post_east;
        val_t post_north;
        val_t post_west;
        val_t post_south;
        val_t post_northeast;
        val_t post_northwest;
        val_t post_southwest;
        val_t post_southeast;
        val_t density;
        val_t velocity_x;
        val_t velocity_y;
    } result_t;

    // Cell data that rides along with the division.
    typedef struct packed {
        pops_t f;
        val_t  rho;
        logic  rho_pos;
        logic  neg_x;
        logic  neg_y;
        logic  ovf_x;
        logic  ovf_y;
    } side_t;

    typedef struct packed {
        side_t          side;
        logic [DW-1:0]  dvs;
        logic [DW-1:0]  rem_x;
        logic [DW-1:0]  rem_y;
        logic [QW-1:0]  num_x;
        logic [QW-1:0]  num_y;
    } div_in_t;

    typedef struct packed {
        side_t          side;
        logic [DW-1:0]  dvs;
        logic [DW-1:0]  rem_x;
        logic [DW-1:0]  rem_y;
        logic [QW-1:0]  num_x;
        logic [QW-1:0]  num_y;
        logic [QW-1:0]  quo_x;
        logic [QW-1:0]  quo_y;
    } div_stage_t;

    typedef struct packed {
        side_t          side;
        logic [QW-1:0]  quo_x;
        logic [QW-1:0]  quo_y;
    } div_out_t;

    // Clamp to the signed value range.
    function automatic val_t sat64(input logic signed [63:0] v);
        val_t r;
        if (v > 64'(VAL_MAX))
            r = VAL_MAX;
        else if (v < 64'(VAL_MIN))
            r = VAL_MIN;
        else
            r = v[VW-1:0];
        return r;
    endfunction

endpackage

@@ design/d2q9_div_pipe.sv @@
module d2q9_div_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  d2q9_pkg::div_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output d2q9_pkg::div_out_t out_data
);
    import d2q9_pkg::*;

    logic [QW-1:0] v_reg;
    div_stage_t    stg_reg  [QW];
    div_stage_t    stg_next [QW];
    div_stage_t    head;
    logic          adv;

    // One restoring step per stage for both lanes.
    function automatic div_stage_t div_step(input div_stage_t s);
        logic [DW:0] tx;
        logic [DW:0] ty;
        logic        gx;
        logic        gy;
        div_stage_t  r;
        r  = s;
        tx = {s.rem_x, s.num_x[QW-1]};
        ty = {s.rem_y, s.num_y[QW-1]};
        gx = tx >= {1'b0, s.dvs};
        gy = ty >= {1'b0, s.dvs};
        r.rem_x = gx ? DW'(tx - {1'b0, s.dvs}) : tx[DW-1:0];
        r.rem_y = gy ? DW'(ty - {1'b0, s.dvs}) : ty[DW-1:0];
        r.num_x = s.num_x << 1;
        r.num_y = s.num_y << 1;
        r.quo_x = {s.quo_x[QW-2:0], gx};
        r.quo_y = {s.quo_y[QW-2:0], gy};
        return r;
    endfunction

    // Whole pipe moves when the last stage is empty or taken.
    assign adv      = !v_reg[QW-1] || !out_stall;
    assign in_stall = !adv;

    always_comb
    begin
        head.side  = in_data.side;
        head.dvs   = in_data.dvs;
        head.rem_x = in_data.rem_x;
        head.rem_y = in_data.rem_y;
        head.num_x = in_data.num_x;
        head.num_y = in_data.num_y;
        head.quo_x = '0;
        head.quo_y = '0;
        stg_next[0] = div_step(head);
        for (int s = 1; s < QW; s++)
        begin
            stg_next[s] = div_step(stg_reg[s-1]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[QW-2:0], in_valid};
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < QW; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    assign out_valid      = v_reg[QW-1];
    assign out_data.side  = stg_reg[QW-1].side;
    assign out_data.quo_x = stg_reg[QW-1].quo_x;
    assign out_data.quo_y = stg_reg[QW-1].quo_y;

endmodule

@@ design/d2q9_bgk_cell_collision.sv @@
// D2Q9 BGK collision, one lattice cell per beat.
// Input channel: cell_valid / cell_stall with the nine populations on
// populations.
// Output channel: result_valid / result_stall with the nine relaxed
// populations, density and velocity in result.
// A beat moves when valid is high and stall is low at a rising edge.
// relax_wr_en / relax_wr_data write omega (Q2.28); write only while idle.
// Throughput: one cell per cycle, sustained while result_stall is low.
// An accepted beat passes through two input stages, the 32-stage velocity
// divider (one quotient bit per stage) and 11 stages of equilibrium and
// relaxation arithmetic on its way to the result beat.
// With result_stall high and a result waiting, the back stages hold, the
// divider holds once its last stage has a beat, and cell_stall rises when
// it holds and the second input stage has a beat; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline and sets omega to 1.0.
`include "d2q9_bgk_cell_collision_macros.svh"

module d2q9_bgk_cell_collision (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    relax_wr_en,
    input  logic [d2q9_pkg::RW-1:0] relax_wr_data,
    input  logic                    cell_valid,
    output logic                    cell_stall,
    input  d2q9_pkg::cell_t         populations,
    output logic                    result_valid,
    input  logic                    result_stall,
    output d2q9_pkg::result_t       result
);
    import d2q9_pkg::*;

    logic [RW-1:0] relax_reg;

    // Front stages
    logic [1:0]                 v_reg;
    logic                       adv_f;
    pops_t                      f_in;
    pops_t                      s1_f_reg;
    logic signed [SUMW-1:0]     s1_sum_reg;
    logic signed [MOMW-1:0]     s1_mx_reg;
    logic signed [MOMW-1:0]     s1_my_reg;
    logic signed [SUMW-1:0]     s1_sum_next;
    logic signed [MOMW-1:0]     s1_mx_next;
    logic signed [MOMW-1:0]     s1_my_next;
    div_in_t                    s2_reg;
    div_in_t                    s2_next;
    logic [MOMW-1:0]            mag_x;
    logic [MOMW-1:0]            mag_y;

    logic     div_in_stall;
    logic     div_out_valid;
    div_out_t div_out;

    // Back stages
    logic [PSTG-1:0] pv_reg;
    logic            adv_p;

    side_t           side_reg [PSTG-1];
    val_t            ux_reg   [PSTG-1];
    val_t            uy_reg   [PSTG-1];
    val_t            ux_next;
    val_t            uy_next;

    logic signed [PW-1:0]   p1_uxx_reg;
    logic signed [PW-1:0]   p1_uyy_reg;
    val_t                   p1_cu_reg  [NDIR];
    val_t                   p2_cu_reg  [NDIR];
    val_t                   p2_sq_reg  [NDIR];
    val_t                   p2_u2_reg;
    val_t                   p3_b_reg   [NDIR];
    val_t                   p4_m_reg   [NDIR];
    logic [MOMW-1:0]        p5_z_reg   [NDIR];
    logic [63:0]            p5_pl_reg  [NDIR];
    logic [MOMW-1:0]        p5_ph_reg  [NDIR];
    logic [MOMW-1:0]        p6_z_reg   [NDIR];
    logic [31:0]            p6_est_reg [NDIR];
    val_t                   p7_feq_reg [NDIR];
    logic signed [VW:0]     p8_dlt_reg [NDIR];
    logic signed [63:0]     p9_prd_reg [NDIR];
    result_t                result_reg;

    logic signed [PW-1:0]   uxx_next;
    logic signed [PW-1:0]   uyy_next;
    val_t                   cu_next    [NDIR];
    val_t                   sq_next    [NDIR];
    val_t                   u2_next;
    val_t                   b_next     [NDIR];
    val_t                   m_next     [NDIR];
    logic [MOMW-1:0]        z_next     [NDIR];
    logic [63:0]            pl_next    [NDIR];
    logic [MOMW-1:0]        ph_next    [NDIR];
    logic [31:0]            est_next   [NDIR];
    val_t                   feq_next   [NDIR];
    logic signed [VW:0]     dlt_next   [NDIR];
    logic signed [63:0]     prd_next   [NDIR];
    val_t                   post_next  [NDIR];

    // Saturated velocity from quotient magnitude and sign; zero unless density is positive.
    function automatic val_t vel_fin(input logic [QW-1:0] q, input logic neg,
                                     input logic ovf, input logic pos);
        val_t r;
        if (!pos)
            r = '0;
        else if (ovf)
            r = neg ? VAL_MIN : VAL_MAX;
        else if (!neg)
            r = q[QW-1] ? VAL_MAX : val_t'(q);
        else if (q > {1'b1, {(QW-1){1'b0}}})
            r = VAL_MIN;
        else
            r = val_t'(-q);
        return r;
    endfunction

    // Relaxation rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_reg <= RELAX_RESET;
        end
        else if (relax_wr_en)
        begin
            relax_reg <= relax_wr_data;
        end
    end

    assign f_in[0] = populations.pop_rest;
    assign f_in[1] = populations.pop_east;
    assign f_in[2] = populations.pop_north;
    assign f_in[3] = populations.pop_west;
    assign f_in[4] = populations.pop_south;
    assign f_in[5] = populations.pop_northeast;
    assign f_in[6] = populations.pop_northwest;
    assign f_in[7] = populations.pop_southwest;
    assign f_in[8] = populations.pop_southeast;

    // Stage 1: moments
    always_comb
    begin
        s1_sum_next = '0;
        s1_mx_next  = '0;
        s1_my_next  = '0;
        for (int q = 0; q < NDIR; q++)
        begin
            s1_sum_next = s1_sum_next + SUMW'(val_t'(f_in[q]));
            if (DIR_X[q] == 1)
                s1_mx_next = s1_mx_next + MOMW'(val_t'(f_in[q]));
            else if (DIR_X[q] == -1)
                s1_mx_next = s1_mx_next - MOMW'(val_t'(f_in[q]));
            if (DIR_Y[q] == 1)
                s1_my_next = s1_my_next + MOMW'(val_t'(f_in[q]));
            else if (DIR_Y[q] == -1)
                s1_my_next = s1_my_next - MOMW'(val_t'(f_in[q]));
        end
    end

    // Stage 2: density, divider operands, quotient overflow check
    always_comb
    begin
        mag_x = s1_mx_reg[MOMW-1] ? MOMW'(-s1_mx_reg) : MOMW'(s1_mx_reg);
        mag_y = s1_my_reg[MOMW-1] ? MOMW'(-s1_my_reg) : MOMW'(s1_my_reg);
        s2_next.side.f       = s1_f_reg;
        s2_next.side.rho     = sat64(64'(s1_sum_reg));
        s2_next.side.rho_pos = s2_next.side.rho > 0;
        s2_next.side.neg_x   = s1_mx_reg[MOMW-1];
        s2_next.side.neg_y   = s1_my_reg[MOMW-1];
        s2_next.dvs          = s2_next.side.rho[DW-1:0];
        s2_next.rem_x        = mag_x[MOMW-1:QW-FB];
        s2_next.rem_y        = mag_y[MOMW-1:QW-FB];
        s2_next.side.ovf_x   = mag_x[MOMW-1:QW-FB] >= s2_next.dvs;
        s2_next.side.ovf_y   = mag_y[MOMW-1:QW-FB] >= s2_next.dvs;
        s2_next.num_x        = {mag_x[QW-FB-1:0], FB'(0)};
        s2_next.num_y        = {mag_y[QW-FB-1:0], FB'(0)};
    end

    assign adv_f      = !v_reg[1] || !div_in_stall;
    assign cell_stall = !adv_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv_f)
        begin
            v_reg <= {v_reg[0], cell_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_f)
        begin
            s1_f_reg   <= f_in;
            s1_sum_reg <= s1_sum_next;
            s1_mx_reg  <= s1_mx_next;
            s1_my_reg  <= s1_my_next;
            s2_reg     <= s2_next;
        end
    end

    d2q9_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[1]),
        .in_stall  (div_in_stall),
        .in_data   (s2_reg),
        .out_valid (div_out_valid),
        .out_stall (!adv_p),
        .out_data  (div_out)
    );

    // Back-end arithmetic, one group per stage
    always_comb
    begin
        // P0: velocity
        ux_next = vel_fin(div_out.quo_x, div_out.side.neg_x, div_out.side.ovf_x,
                          div_out.side.rho_pos);
        uy_next = vel_fin(div_out.quo_y, div_out.side.neg_y, div_out.side.ovf_y,
                          div_out.side.rho_pos);
        // P1: squares of velocity, projections
        uxx_next = PW'((64'(ux_reg[0]) * 64'(ux_reg[0])) >>> FB);
        uyy_next = PW'((64'(uy_reg[0]) * 64'(uy_reg[0])) >>> FB);
        // P2: u^2 and projection squares
        u2_next = sat64(64'(p1_uxx_reg) + 64'(p1_uyy_reg));
        for (int q = 0; q < NDIR; q++)
        begin
            logic signed [VW+1:0] ax;
            logic signed [VW+1:0] ay;
            logic signed [63:0]   bt;
            logic signed [MOMW-1:0] y;
            logic [67:0]          acc;
            logic [SUMW-1:0]      rr;
            logic [31:0]          qi;
            logic signed [QW:0]   tq;
            ax = (DIR_X[q] == 1) ? (VW+2)'(ux_reg[0]) :
                 (DIR_X[q] == -1) ? -(VW+2)'(ux_reg[0]) : '0;
            ay = (DIR_Y[q] == 1) ? (VW+2)'(uy_reg[0]) :
                 (DIR_Y[q] == -1) ? -(VW+2)'(uy_reg[0]) : '0;
            cu_next[q] = sat64(64'(ax + ay));
            sq_next[q] = sat64((64'(p1_cu_reg[q]) * 64'(p1_cu_reg[q])) >>> FB);
            // P3: polynomial
            bt = 64'(ONE_Q) + 64'(p2_cu_reg[q]) * 64'sd3
                 + ((64'(p2_sq_reg[q]) * 64'sd9) >>> 1)
                 - ((64'(p2_u2_reg) * 64'sd3) >>> 1);
            b_next[q] = sat64(bt);
            // P4: scale by density
            m_next[q] = sat64((64'(side_reg[3].rho) * 64'(p3_b_reg[q])) >>> FB);
            // P5: weight, bias and reciprocal partial products
            if (WEIGHT36[q] == 16)
                y = MOMW'(p4_m_reg[q]) <<< 2;
            else if (WEIGHT36[q] == 4)
                y = MOMW'(p4_m_reg[q]);
            else
                y = MOMW'(p4_m_reg[q]) >>> 2;
            z_next[q]  = MOMW'(y) + FEQ_OFFSET;
            pl_next[q] = 64'(z_next[q][31:0]) * 64'(RECIP9);
            ph_next[q] = MOMW'(z_next[q][MOMW-1:32]) * MOMW'(RECIP9);
            // P6: quotient estimate
            acc = 68'(p5_pl_reg[q]) + {1'b0, p5_ph_reg[q], 32'b0};
            est_next[q] = acc[66:35];
            // P7: correction and bias removal
            rr = SUMW'(p6_z_reg[q]) - SUMW'(p6_est_reg[q]) * SUMW'(9);
            qi = p6_est_reg[q] + ((rr >= SUMW'(9)) ? 32'd1 : 32'd0);
            tq = $signed({1'b0, qi}) - $signed(FEQ_BIAS);
            feq_next[q] = tq[VW-1:0];
            // P8: distance to equilibrium
            dlt_next[q] = (VW+1)'(p7_feq_reg[q]) - (VW+1)'(val_t'(side_reg[7].f[q]));
            // P9: times omega
            prd_next[q] = 64'(p8_dlt_reg[q]) * 64'($signed({1'b0, relax_reg}));
            // P10: relaxed population
            post_next[q] = sat64(64'(val_t'(side_reg[9].f[q])) + (p9_prd_reg[q] >>> FB));
        end
    end

    assign adv_p = !pv_reg[PSTG-1] || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else if (adv_p)
        begin
            pv_reg <= {pv_reg[PSTG-2:0], div_out_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_p)
        begin
            side_reg[0] <= div_out.side;
            ux_reg[0]   <= ux_next;
            uy_reg[0]   <= uy_next;
            for (int s = 1; s < PSTG - 1; s++)
            begin
                side_reg[s] <= side_reg[s-1];
                ux_reg[s]   <= ux_reg[s-1];
                uy_reg[s]   <= uy_reg[s-1];
            end
            p1_uxx_reg <= uxx_next;
            p1_uyy_reg <= uyy_next;
            p2_u2_reg  <= u2_next;
            for (int q = 0; q < NDIR; q++)
            begin
                p1_cu_reg[q]  <= cu_next[q];
                p2_cu_reg[q]  <= p1_cu_reg[q];
                p2_sq_reg[q]  <= sq_next[q];
                p3_b_reg[q]   <= b_next[q];
                p4_m_reg[q]   <= m_next[q];
                p5_z_reg[q]   <= z_next[q];
                p5_pl_reg[q]  <= pl_next[q];
                p5_ph_reg[q]  <= ph_next[q];
                p6_z_reg[q]   <= p5_z_reg[q];
                p6_est_reg[q] <= est_next[q];
                p7_feq_reg[q] <= feq_next[q];
                p8_dlt_reg[q] <= dlt_next[q];
                p9_prd_reg[q] <= prd_next[q];
            end
            result_reg.post_rest      <= post_next[0];
            result_reg.post_east      <= post_next[1];
            result_reg.post_north     <= post_next[2];
            result_reg.post_west      <= post_next[3];
            result_reg.post_south     <= post_next[4];
            result_reg.post_northeast <= post_next[5];
            result_reg.post_northwest <= post_next[6];
            result_reg.post_southwest <= post_next[7];
            result_reg.post_southeast <= post_next[8];
            result_reg.density        <= side_reg[PSTG-2].rho;
            result_reg.velocity_x     <= ux_reg[PSTG-2];
            result_reg.velocity_y     <= uy_reg[PSTG-2];
        end
    end

    assign result_valid = pv_reg[PSTG-1];
    assign result       = result_reg;

    // Checks
    `D2Q9_ASSERT_IMPLY(a_vel_zero, clk, rst_n, result_valid && ($signed(result.density) <= 0), (result.velocity_x == 0) && (result.velocity_y == 0), "velocity not zero for non-positive density")
    `D2Q9_ASSERT_NEXT(a_last_stage, clk, rst_n, pv_reg[PSTG-2] && adv_p, result_valid, "result beat lost at output stage")
    `D2Q9_ASSERT_IMPLY(a_div_hold, clk, rst_n, div_in_stall, result_valid && result_stall, "divider held without an output stall")

endmodule
